FILE: hw/rtl/rms_pkg.sv
package rms_pkg;

    localparam int unsigned MAX_RECORDS_DEF = 64;
    localparam int unsigned ID_W    = 31;
    localparam int unsigned SCORE_W = 7;
    localparam int unsigned TOTAL_W = 9;
    localparam int unsigned KEY_W   = TOTAL_W + 3 * SCORE_W + ID_W;

    typedef struct packed {
        logic [ID_W-1:0]    student_id;
        logic [SCORE_W-1:0] score_a;
        logic [SCORE_W-1:0] score_b;
        logic [SCORE_W-1:0] score_c;
        logic [SCORE_W-1:0] score_d;
        logic               final_record;
    } t_rms_in;

    typedef struct packed {
        logic [ID_W-1:0]    out_id;
        logic [SCORE_W-1:0] out_a;
        logic [SCORE_W-1:0] out_b;
        logic [SCORE_W-1:0] out_c;
        logic [SCORE_W-1:0] out_d;
        logic [TOTAL_W-1:0] out_total;
        logic               out_last;
        logic               overflow;
    } t_rms_out;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] a;
        logic [SCORE_W-1:0] b;
        logic [SCORE_W-1:0] c;
        logic [SCORE_W-1:0] d;
        logic [TOTAL_W-1:0] total;
    } t_rms_rec;

    typedef struct packed {
        logic     valid;
        t_rms_rec rec;
    } t_rms_slot;

    typedef struct packed {
        logic ins;
        logic shift;
    } t_rms_ctl;

    // Larger key ranks first; the inverted id makes the lower id win the last tie.
    function automatic logic [KEY_W-1:0] rms_key(input t_rms_rec r);
        return {r.total, r.a, r.b, r.c, ~r.id};
    endfunction

endpackage

FILE: hw/rtl/rms_cell.sv
module rms_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rms_pkg::t_rms_ctl i_ctl,
    input  rms_pkg::t_rms_rec i_new,
    input  rms_pkg::t_rms_slot i_left,
    input  logic              i_left_less,
    input  rms_pkg::t_rms_slot i_right,
    output rms_pkg::t_rms_slot o_slot,
    output logic              o_less
);

    logic              r_valid;
    rms_pkg::t_rms_rec r_rec;
    logic              n_valid;
    rms_pkg::t_rms_rec n_rec;

    // new record ranks ahead of what this cell holds (empty cells lose to anything)
    assign o_less = !r_valid || (rms_pkg::rms_key(i_new) > rms_pkg::rms_key(r_rec));
    assign o_slot = '{valid: r_valid, rec: r_rec};

    always_comb begin
        n_valid = r_valid;
        n_rec   = r_rec;
        if (i_ctl.shift) begin
            n_valid = i_right.valid;
            n_rec   = i_right.rec;
        end else if (i_ctl.ins && o_less) begin
            if (i_left_less) begin
                // make room: take the left neighbor, which moves one place down
                n_valid = i_left.valid;
                n_rec   = i_left.rec;
            end else begin
                n_valid = 1'b1;
                n_rec   = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

FILE: hw/rtl/record_multikey_sorter.sv
// Collects records into a sorted chain of cells, one record per accepted beat;
// busy stays low while loading. On the beat marked final the block raises busy
// the next cycle and emits the stored records, best first, one beat per cycle
// on o_strobe, with out_last on the final one; busy drops the cycle after that.
// The receiver cannot stall: every strobe beat must be taken. Order is total
// descending, then score a, b, c descending, then id ascending. Records beyond
// MAX_RECORDS are dropped and flagged by overflow on every beat of that run.
// No clearing pass after reset.
module record_multikey_sorter #(
    parameter int unsigned MAX_RECORDS = rms_pkg::MAX_RECORDS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  rms_pkg::t_rms_in i_data,
    output logic             o_strobe,
    output rms_pkg::t_rms_out o_result
);

    localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

    logic          r_busy;
    logic [CW-1:0] r_count;
    logic          r_dropped;

    logic              accept;
    logic              full;
    rms_pkg::t_rms_ctl ctl;
    rms_pkg::t_rms_rec new_rec;

    rms_pkg::t_rms_slot slot  [MAX_RECORDS];
    rms_pkg::t_rms_slot left  [MAX_RECORDS];
    rms_pkg::t_rms_slot right [MAX_RECORDS];
    logic               less  [MAX_RECORDS];
    logic               left_less [MAX_RECORDS];

    assign accept = start && !r_busy;
    assign full   = (r_count == CW'(MAX_RECORDS));
    assign ctl    = '{ins: accept && !full, shift: r_busy};

    always_comb begin
        new_rec.id    = i_data.student_id;
        new_rec.a     = i_data.score_a;
        new_rec.b     = i_data.score_b;
        new_rec.c     = i_data.score_c;
        new_rec.d     = i_data.score_d;
        new_rec.total = rms_pkg::TOTAL_W'(i_data.score_a) + rms_pkg::TOTAL_W'(i_data.score_b)
                      + rms_pkg::TOTAL_W'(i_data.score_c) + rms_pkg::TOTAL_W'(i_data.score_d);
    end

    for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign left[g]      = '0;
            assign left_less[g] = 1'b0;
        end else begin : g_body
            assign left[g]      = slot[g-1];
            assign left_less[g] = less[g-1];
        end
        if (g == MAX_RECORDS - 1) begin : g_tail
            assign right[g] = '0;
        end else begin : g_inner
            assign right[g] = slot[g+1];
        end

        rms_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_new       (new_rec),
            .i_left      (left[g]),
            .i_left_less (left_less[g]),
            .i_right     (right[g]),
            .o_slot      (slot[g]),
            .o_less      (less[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (r_busy) begin
            // drain: the head goes out and the chain moves up one place
            r_count <= r_count - CW'(1);
            if (r_count == CW'(1)) begin
                r_busy    <= 1'b0;
                r_dropped <= 1'b0;
            end
        end else if (accept) begin
            if (full) begin
                r_dropped <= 1'b1;
            end else begin
                r_count <= r_count + CW'(1);
            end
            r_busy <= i_data.final_record;
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_busy;

    always_comb begin
        o_result.out_id    = slot[0].rec.id;
        o_result.out_a     = slot[0].rec.a;
        o_result.out_b     = slot[0].rec.b;
        o_result.out_c     = slot[0].rec.c;
        o_result.out_d     = slot[0].rec.d;
        o_result.out_total = slot[0].rec.total;
        o_result.out_last  = (r_count == CW'(1));
        o_result.overflow  = r_dropped;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RECORDS))
        else $error("record count beyond capacity");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.out_last |=> !busy && r_count == '0 && !r_dropped)
        else $error("run did not close after last beat");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.out_last |=> o_strobe)
        else $error("run broke off before last beat");

    a_drop_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && full |=> r_dropped)
        else $error("dropped record not flagged");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> slot[0].valid)
        else $error("beat emitted from empty cell");
`endif

endmodule

FILE: verif/record_multikey_sorter_tb.sv
module record_multikey_sorter_tb;

    import rms_pkg::*;

    localparam int CAPACITY    = MAX_RECORDS_DEF;
    localparam int QUIET_LIMIT = 20 * CAPACITY + 1000;
    localparam int TAIL_CYCLES = 2 * CAPACITY + 16;

    typedef struct {
        t_rms_in  beat;
        bit       typed;
        t_rms_out want;
    } t_row;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_rms_in  i_data  = '0;
    logic     busy;
    logic     o_strobe;
    t_rms_out o_result;

    // ranking predictor state
    t_rms_rec held_rec[CAPACITY];
    int       held_count   = 0;
    bit       held_dropped = 1'b0;
    t_rms_out fresh_ranks[$];
    t_rms_out pending_ranks[$];

    t_row     script[$];
    int       beats_sent = 0;
    int       errors     = 0;
    int       quiet      = 0;

    record_multikey_sorter #(
        .MAX_RECORDS(CAPACITY)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_data  (i_data),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit ranks_ahead(input t_rms_rec x, input t_rms_rec y);
        if (x.total != y.total) return x.total > y.total;
        if (x.a != y.a) return x.a > y.a;
        if (x.b != y.b) return x.b > y.b;
        if (x.c != y.c) return x.c > y.c;
        return x.id < y.id;
    endfunction

    // Store one beat; on the final beat, rank the held records into fresh_ranks.
    function automatic void absorb_record(input t_rms_in beat);
        t_rms_rec sorted[CAPACITY];
        t_rms_rec cur;
        t_rms_out res;
        int       i;
        int       j;
        cur.id    = beat.student_id;
        cur.a     = beat.score_a;
        cur.b     = beat.score_b;
        cur.c     = beat.score_c;
        cur.d     = beat.score_d;
        cur.total = TOTAL_W'(beat.score_a) + TOTAL_W'(beat.score_b) +
                    TOTAL_W'(beat.score_c) + TOTAL_W'(beat.score_d);
        fresh_ranks.delete();
        if (held_count < CAPACITY) begin
            held_rec[held_count] = cur;
            held_count++;
        end else begin
            held_dropped = 1'b1;
        end
        if (beat.final_record) begin
            for (i = 0; i < held_count; i++) begin
                j = i;
                while (j > 0 && ranks_ahead(held_rec[i], sorted[j-1])) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = held_rec[i];
            end
            for (i = 0; i < held_count; i++) begin
                res.out_id    = sorted[i].id;
                res.out_a     = sorted[i].a;
                res.out_b     = sorted[i].b;
                res.out_c     = sorted[i].c;
                res.out_d     = sorted[i].d;
                res.out_total = sorted[i].total;
                res.out_last  = (i == held_count - 1);
                res.overflow  = held_dropped;
                fresh_ranks.push_back(res);
            end
            held_count   = 0;
            held_dropped = 1'b0;
        end
    endfunction

    function automatic t_rms_in mk_in(input logic [ID_W-1:0] id, input int a, input int b,
                                      input int c, input int d, input bit fin);
        t_rms_in r;
        r.student_id   = id;
        r.score_a      = SCORE_W'(a);
        r.score_b      = SCORE_W'(b);
        r.score_c      = SCORE_W'(c);
        r.score_d      = SCORE_W'(d);
        r.final_record = fin;
        return r;
    endfunction

    // Typed expectation for a one-record run.
    function automatic t_rms_out mk_out(input t_rms_in beat, input int total);
        t_rms_out r;
        r.out_id    = beat.student_id;
        r.out_a     = beat.score_a;
        r.out_b     = beat.score_b;
        r.out_c     = beat.score_c;
        r.out_d     = beat.score_d;
        r.out_total = TOTAL_W'(total);
        r.out_last  = 1'b1;
        r.overflow  = 1'b0;
        return r;
    endfunction

    function automatic void add_row(input t_rms_in beat, input bit typed, input t_rms_out want);
        t_row r;
        r.beat  = beat;
        r.typed = typed;
        r.want  = want;
        script.push_back(r);
    endfunction

    function automatic t_rms_in rand_record(input bit tied, input bit fin);
        t_rms_in r;
        if (tied) begin
            // narrow range makes equal totals and repeated keys likely
            r = mk_in(ID_W'($urandom_range(0, 3)), $urandom_range(40, 42),
                      $urandom_range(40, 42), $urandom_range(40, 42),
                      $urandom_range(40, 42), fin);
        end else if ($urandom_range(0, 7) == 0) begin
            r = mk_in(ID_W'($urandom), $urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom_range(0, 127), $urandom_range(0, 127), fin);
        end else begin
            r = mk_in(ID_W'($urandom), $urandom_range(0, 100), $urandom_range(0, 100),
                      $urandom_range(0, 100), $urandom_range(0, 100), fin);
        end
        return r;
    endfunction

    task automatic feed(input t_rms_in beat, input int idle_pct, input bit typed,
                        input t_rms_out want);
        int gap;
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_data <= beat;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        beats_sent++;
        absorb_record(beat);
        if (typed && beat.final_record) begin
            pending_ranks.push_back(want);
        end else begin
            foreach (fresh_ranks[k]) pending_ranks.push_back(fresh_ranks[k]);
        end
    endtask

    task automatic run_set(input int n, input int idle_pct);
        bit tied;
        int k;
        tied = ($urandom_range(0, 3) == 0);
        for (k = 0; k < n; k++) feed(rand_record(tied, k == n - 1), idle_pct, 1'b0, '0);
    endtask

    // Hold the sender until the block has emitted everything.
    task automatic hold_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_ranks.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_rms_out want;
        if (i_rst_n && o_strobe) begin
            if (pending_ranks.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %p", $time, o_result);
                errors++;
            end else begin
                want = pending_ranks.pop_front();
                check_field("out_id",    32'(want.out_id),    32'(o_result.out_id));
                check_field("out_a",     32'(want.out_a),     32'(o_result.out_a));
                check_field("out_b",     32'(want.out_b),     32'(o_result.out_b));
                check_field("out_c",     32'(want.out_c),     32'(o_result.out_c));
                check_field("out_d",     32'(want.out_d),     32'(o_result.out_d));
                check_field("out_total", 32'(want.out_total), 32'(o_result.out_total));
                check_field("out_last",  32'(want.out_last),  32'(o_result.out_last));
                check_field("overflow",  32'(want.overflow),  32'(o_result.overflow));
            end
        end
    end

    // only accepted input beats and expected result beats count as progress, so a stuck strobe cannot hang the run
    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || (o_strobe && pending_ranks.size() != 0)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_rms_in t;
        int      mark;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-record runs at the field extremes and at score 100
        t = mk_in(31'h7fffffff, 127, 127, 127, 127, 1'b1);
        add_row(t, 1'b1, mk_out(t, 508));
        t = mk_in(31'h0, 0, 0, 0, 0, 1'b1);
        add_row(t, 1'b1, mk_out(t, 0));
        t = mk_in(31'd5, 100, 100, 100, 100, 1'b1);
        add_row(t, 1'b1, mk_out(t, 400));
        // equal totals broken by a, then b, then c, then id; a duplicate record
        add_row(mk_in(31'd10, 50, 50, 50, 50, 1'b0), 1'b0, '0);
        add_row(mk_in(31'd11, 60, 40, 50, 50, 1'b0), 1'b0, '0);
        add_row(mk_in(31'd12, 60, 50, 40, 50, 1'b0), 1'b0, '0);
        add_row(mk_in(31'd13, 60, 50, 45, 45, 1'b0), 1'b0, '0);
        add_row(mk_in(31'd9,  60, 50, 45, 45, 1'b0), 1'b0, '0);
        add_row(mk_in(31'd9,  60, 50, 45, 45, 1'b0), 1'b0, '0);
        add_row(mk_in(31'd20, 0, 0, 0, 127, 1'b0), 1'b0, '0);
        add_row(mk_in(31'd21, 127, 0, 0, 0, 1'b0), 1'b0, '0);
        add_row(mk_in(31'h7fffffff, 0, 0, 0, 0, 1'b0), 1'b0, '0);
        add_row(mk_in(31'd22, 1, 1, 1, 1, 1'b1), 1'b0, '0);
        // arrival order opposite to rank order
        add_row(mk_in(31'd100, 10, 10, 10, 10, 1'b0), 1'b0, '0);
        add_row(mk_in(31'd101, 90, 90, 90, 90, 1'b1), 1'b0, '0);
        add_row(mk_in(31'h40000000, 33, 33, 33, 33, 1'b0), 1'b0, '0);
        add_row(mk_in(31'h3fffffff, 33, 33, 33, 33, 1'b1), 1'b0, '0);

        foreach (script[r]) feed(script[r].beat, 0, script[r].typed, script[r].want);
        hold_until_drained();

        mark = beats_sent + 10;
        while (beats_sent < mark) run_set($urandom_range(1, 8), 25);
        hold_until_drained();

        // overfill the store; the final beat itself is dropped
        run_set(CAPACITY + 2, 48);
        mark = beats_sent + 6;
        while (beats_sent < mark) run_set($urandom_range(1, 6), 48);
        hold_until_drained();

        mark = beats_sent + 10;
        while (beats_sent < mark) run_set($urandom_range(1, 8), 0);

        start <= 1'b0;
        @(posedge i_clk);
        while (pending_ranks.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
